>>> rtl/core/opi_pkg.sv
// opi_pkg: shared constants, types and arctangent table for the pose integrator
// no dependencies
`default_nettype none
package opi_pkg;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;
  localparam logic [15:0] PERIOD_RESET = 16'd1311;
  localparam int MUL_W = 64;
  localparam int MUL_CNT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INC, ST_ROT, ST_DIST, ST_MULX, ST_MULY, ST_ACC, ST_OUT
  } state_t;

  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/opi_serial_mul.sv
// opi_serial_mul: signed shift-add multiplier, one multiplier bit per cycle
// depends on opi_pkg
`default_nettype none
module opi_serial_mul (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [opi_pkg::MUL_W-1:0] a,
  input  wire logic signed [opi_pkg::MUL_W-1:0] b,
  output logic                                 done,
  output logic signed [opi_pkg::MUL_W-1:0]      p
);
  logic [opi_pkg::MUL_CNT_W-1:0] cnt;
  logic signed [opi_pkg::MUL_W-1:0] mcand;
  logic [opi_pkg::MUL_W-1:0] mplier;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      mcand <= a;
      mplier <= b;
      p <= '0;
      done <= 1'b0;
    end else if (busy) begin
      // top multiplier bit carries negative weight (two's complement)
      if (mplier[0]) begin
        if (cnt == opi_pkg::MUL_CNT_W'(opi_pkg::MUL_W - 1)) p <= p - mcand;
        else p <= p + mcand;
      end
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt <= cnt + 1'b1;
      busy <= (cnt != opi_pkg::MUL_CNT_W'(opi_pkg::MUL_W - 1));
      done <= (cnt == opi_pkg::MUL_CNT_W'(opi_pkg::MUL_W - 1));
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/opi_cordic.sv
// opi_cordic: iterated rotation-mode cordic, one micro-rotation per cycle
// depends on opi_pkg
`default_nettype none
module opi_cordic (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [31:0]  angle,
  output logic                     done,
  output logic signed [33:0]       cos_q30,
  output logic signed [33:0]       sin_q30
);
  logic signed [35:0] x, y, z;
  logic [opi_pkg::STEP_W-1:0] i;
  logic busy, neg;
  logic signed [35:0] z0;

  always_comb z0 = 36'(angle) <<< 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      i <= '0;
      x <= 36'(opi_pkg::GAIN_Q30);
      y <= '0;
      if (z0 > 36'(opi_pkg::HALF_PI_Q30)) begin
        z <= z0 - 36'(opi_pkg::PI_Q30); neg <= 1'b1;
      end else if (z0 < -36'(opi_pkg::HALF_PI_Q30)) begin
        z <= z0 + 36'(opi_pkg::PI_Q30); neg <= 1'b1;
      end else begin
        z <= z0; neg <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> i);
        y <= y + (x >>> i);
        z <= z - 36'(opi_pkg::atan_q30(i));
      end else begin
        x <= x + (y >>> i);
        y <= y - (x >>> i);
        z <= z + 36'(opi_pkg::atan_q30(i));
      end
      i <= i + 1'b1;
      busy <= (i != opi_pkg::STEP_W'(opi_pkg::CORDIC_STEPS - 1));
      done <= (i == opi_pkg::STEP_W'(opi_pkg::CORDIC_STEPS - 1));
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    cos_q30 = neg ? 34'(-x) : 34'(x);
    sin_q30 = neg ? 34'(-y) : 34'(y);
  end
endmodule
`default_nettype wire

>>> rtl/core/odometry_pose_integrator_unit.sv
// odometry_pose_integrator_unit: top level, sequencer, pose state and output register
// depends on opi_pkg, opi_cordic, opi_serial_mul
// each request runs four serial multiplies in turn on the shared multiplier before out_valid
// the 24-step cordic runs under the distance multiply
// a new request is accepted only in idle, once the previous result has been taken
// reset: synchronous rst clears pose, heading and handshakes, period returns to 1311
`default_nettype none
module odometry_pose_integrator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] linear_speed,
  input  wire logic signed [23:0] turn_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      pos_x,
  output logic signed [47:0]      pos_y,
  output logic signed [30:0]      heading,
  output logic signed [23:0]      speed_echo,
  output logic signed [23:0]      rate_echo,
  output logic                    turn_clamped,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data
);
  opi_pkg::state_t state, state_next;
  logic [15:0] step_period;
  logic signed [31:0] heading_acc;
  logic signed [47:0] x_acc, y_acc;
  logic signed [23:0] lin_r, rate_r;
  logic signed [63:0] dist_q24, dx, dy;
  logic clamp_r;

  // shared multiplier
  logic mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_p;
  // cordic
  logic cor_start, cor_done;
  logic signed [33:0] cos_q30, sin_q30;
  logic cor_seen;

  // heading increment path, rounded from the multiplier product
  logic signed [63:0] inc_full;
  logic signed [31:0] inc_sat, th;
  logic inc_clip;
  logic signed [63:0] dx_r, dy_r;
  logic signed [48:0] xs, ys;

  // distance multiply kicks off once, on the first cycle in ST_DIST
  logic dist_go;

  opi_serial_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                        .done(mul_done), .p(mul_p));
  // cordic takes the freshly wrapped heading in the same cycle it is stored
  opi_cordic u_cor (.clk, .rst, .start(cor_start), .angle(th),
                    .done(cor_done), .cos_q30, .sin_q30);

  always_comb begin
    inc_full = (mul_p + 64'sd8) >>> 4;
    inc_clip = 1'b0;
    if (inc_full > 64'(opi_pkg::PI_Q28)) begin
      inc_sat = opi_pkg::PI_Q28; inc_clip = 1'b1;
    end else if (inc_full < -64'(opi_pkg::PI_Q28)) begin
      inc_sat = -opi_pkg::PI_Q28; inc_clip = 1'b1;
    end else inc_sat = 32'(inc_full);
    th = heading_acc + inc_sat;
    if (th > opi_pkg::PI_Q28) th = th - opi_pkg::TWO_PI_Q28;
    else if (th < -opi_pkg::PI_Q28) th = th + opi_pkg::TWO_PI_Q28;
    dx_r = (dx + (64'sd1 <<< 37)) >>> 38;
    dy_r = (dy + (64'sd1 <<< 37)) >>> 38;
    xs = 49'(x_acc) + 49'(dx_r);
    ys = 49'(y_acc) + 49'(dy_r);
  end

  // sequencer: inc multiply, then cordic and distance multiply, then two products
  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    cor_start = 1'b0;
    mul_a = 64'(rate_r);
    mul_b = 64'($signed({1'b0, step_period}));
    in_ready = 1'b0;
    unique case (state)
      opi_pkg::ST_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && in_ready) state_next = opi_pkg::ST_INC;
      end
      opi_pkg::ST_INC: begin
        mul_start = 1'b1;
        state_next = opi_pkg::ST_ROT;
      end
      opi_pkg::ST_ROT: begin
        if (mul_done) begin
          cor_start = 1'b1;
          state_next = opi_pkg::ST_DIST;
        end
      end
      opi_pkg::ST_DIST: begin
        mul_a = 64'(lin_r);
        mul_start = dist_go;
        if (mul_done) state_next = opi_pkg::ST_MULX;
      end
      opi_pkg::ST_MULX: begin
        mul_a = dist_q24;
        mul_b = 64'(cos_q30);
        if (cor_seen) begin
          mul_start = 1'b1;
          state_next = opi_pkg::ST_MULY;
        end
      end
      opi_pkg::ST_MULY: begin
        mul_a = dist_q24;
        mul_b = 64'(sin_q30);
        if (mul_done) begin
          mul_start = 1'b1;
          state_next = opi_pkg::ST_ACC;
        end
      end
      opi_pkg::ST_ACC: begin
        mul_a = dist_q24;
        mul_b = 64'(sin_q30);
        if (mul_done) state_next = opi_pkg::ST_OUT;
      end
      opi_pkg::ST_OUT: state_next = opi_pkg::ST_IDLE;
      default: state_next = opi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= opi_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= opi_pkg::PERIOD_RESET;
      heading_acc <= '0;
      x_acc <= '0;
      y_acc <= '0;
      out_valid <= 1'b0;
      cor_seen <= 1'b0;
      dist_go <= 1'b0;
    end else begin
      if (cfg_we) step_period <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cor_done) cor_seen <= 1'b1;
      dist_go <= (state == opi_pkg::ST_ROT) && mul_done;
      unique case (state)
        opi_pkg::ST_IDLE: if (in_valid && in_ready) begin
          lin_r <= linear_speed;
          rate_r <= turn_rate;
          cor_seen <= 1'b0;
          dist_q24 <= '0;
        end
        opi_pkg::ST_ROT: if (mul_done) begin
          heading_acc <= th;
          clamp_r <= inc_clip;
        end
        opi_pkg::ST_DIST: if (mul_done) dist_q24 <= (mul_p + 64'sd128) >>> 8;
        opi_pkg::ST_MULY: if (mul_done) dx <= mul_p;
        opi_pkg::ST_ACC: if (mul_done) dy <= mul_p;
        opi_pkg::ST_OUT: begin
          // saturate onto the 48 bit range
          if (xs > 49'(opi_pkg::POS_MAX)) x_acc <= opi_pkg::POS_MAX;
          else if (xs < 49'(opi_pkg::POS_MIN)) x_acc <= opi_pkg::POS_MIN;
          else x_acc <= 48'(xs);
          if (ys > 49'(opi_pkg::POS_MAX)) y_acc <= opi_pkg::POS_MAX;
          else if (ys < 49'(opi_pkg::POS_MIN)) y_acc <= opi_pkg::POS_MIN;
          else y_acc <= 48'(ys);
          pos_x <= (xs > 49'(opi_pkg::POS_MAX)) ? opi_pkg::POS_MAX :
                   (xs < 49'(opi_pkg::POS_MIN)) ? opi_pkg::POS_MIN : 48'(xs);
          pos_y <= (ys > 49'(opi_pkg::POS_MAX)) ? opi_pkg::POS_MAX :
                   (ys < 49'(opi_pkg::POS_MIN)) ? opi_pkg::POS_MIN : 48'(ys);
          heading <= 31'(heading_acc);
          speed_echo <= lin_r;
          rate_echo <= rate_r;
          turn_clamped <= clamp_r;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/opi_checker.sv
// opi_checker: port-level assertions for the pose integrator, bound to the top level
// depends on odometry_pose_integrator_unit
`default_nettype none
module opi_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [30:0] heading,
  input wire logic signed [47:0] pos_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x)) else $error("out dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading <= 31'sd843314857) && (heading >= -31'sd843314857))
    else $error("heading out of range");
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind odometry_pose_integrator_unit opi_checker u_opi_checker (.*);
`default_nettype wire
